// ===== src/cswb_pkg.sv =====
// Package for the count-smallest-within-budget block.
// Holds the sizes, operation codes, state encoding and the compare/add and memory request types.
// No dependencies.
package cswb_pkg;

  localparam int unsigned Capacity  = 1024;
  localparam int unsigned IdxW      = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned ValueW    = 20;
  localparam int unsigned SumW      = 31;
  localparam int unsigned BudgetW   = 32;
  localparam int unsigned CmpW      = 32;
  localparam int unsigned EntryW    = ValueW + SumW;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LRD  = 5'b00010,
    S_LCMP = 5'b00100,
    S_QRD  = 5'b01000,
    S_QCMP = 5'b10000
  } state_e;

  typedef struct packed {
    logic [CmpW-1:0] cmp_a;
    logic [CmpW-1:0] cmp_b;
    logic [SumW-1:0] add_a;
    logic [SumW-1:0] add_b;
  } alu_req_t;

  typedef struct packed {
    logic            gt;
    logic [SumW-1:0] sum;
  } alu_rsp_t;

  typedef struct packed {
    logic              we;
    logic [IdxW-1:0]   waddr;
    logic [EntryW-1:0] wdata;
    logic [IdxW-1:0]   raddr;
  } mem_req_t;

endpackage

// ===== src/cswb_mem.sv =====
// Entry store for the sorted values and their prefix sums.
// One write port and one registered read port; depends on cswb_pkg.
module cswb_mem import cswb_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// ===== src/cswb_alu.sv =====
// Shared compare and add unit used by the insertion and search sequences.
// Depends on cswb_pkg.
module cswb_alu import cswb_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  assign rsp_o.gt  = (req_i.cmp_a > req_i.cmp_b);
  assign rsp_o.sum = req_i.add_a + req_i.add_b;

endmodule

// ===== src/count_smallest_within_budget.sv =====
// Top level of the count-smallest-within-budget block: sequencer and result register.
// Depends on cswb_pkg, cswb_mem and cswb_alu.
//
// The block keeps up to 1024 values in ascending order with their prefix sums in one
// memory with a registered read port. A clear empties the set. A load walks down from
// the top entry, moving each larger entry up by one slot, with a read step and a compare
// step per moved entry; a load into a full set only sets the overflow flag. A query runs
// an upper-bound binary search on the prefix sums, with a read and a compare step per probe.
// Both sequences are paced by the single memory read port and the one shared compare unit.
// Input is not taken while an item is in work; a query result waits in the output
// register and the next item may be taken while it does.
module count_smallest_within_budget import cswb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // value[19:0], budget[51:20]
  input  logic [1:0]          s_axis_tuser,   // operation[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // count[10:0], overflowed[11]
);

  state_e             state_q, state_d;
  logic [CntW-1:0]    n_q, n_d;
  logic               ovf_q, ovf_d;
  logic [ValueW-1:0]  v_q, v_d;
  logic [BudgetW-1:0] budget_q, budget_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    lo_q, lo_d;
  logic [CntW-1:0]    hi_q, hi_d;
  logic [CntW-1:0]    mid_q, mid_d;
  logic               out_valid_q, out_valid_d;
  logic [CntW-1:0]    out_count_q, out_count_d;
  logic               out_ovf_q, out_ovf_d;

  mem_req_t           mem_req;
  logic [EntryW-1:0]  rdata;
  logic [ValueW-1:0]  rd_value;
  logic [SumW-1:0]    rd_sum;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [CntW-1:0]    idx_m1;
  logic [CntW-1:0]    mid_calc;
  logic               out_free;
  op_e                op_in;

  cswb_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  cswb_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign rd_sum   = rdata[SumW-1:0];
  assign rd_value = rdata[EntryW-1:SumW];
  assign idx_m1   = idx_q - CntW'(1);
  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);
  assign out_free = !out_valid_q || m_axis_tready;
  assign op_in    = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - CntW - 1){1'b0}}, out_ovf_q, out_count_q};

  always_comb begin
    alu_req.add_a = rd_sum;
    alu_req.add_b = SumW'(v_q);
    if (state_q == S_QCMP) begin
      alu_req.cmp_a = CmpW'(rd_sum);
      alu_req.cmp_b = CmpW'(budget_q);
    end else begin
      alu_req.cmp_a = CmpW'(rd_value);
      alu_req.cmp_b = CmpW'(v_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ovf_d       = ovf_q;
    v_d         = v_q;
    budget_d    = budget_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_q[IdxW-1:0];
    mem_req.wdata = {rd_value, alu_rsp.sum};
    mem_req.raddr = idx_m1[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (op_in)
            OP_CLEAR: begin
              n_d   = '0;
              ovf_d = 1'b0;
            end
            OP_LOAD: begin
              if (n_q == CntW'(Capacity)) begin
                ovf_d = 1'b1;
              end else begin
                v_d     = s_axis_tdata[ValueW-1:0];
                idx_d   = n_q;
                state_d = S_LRD;
              end
            end
            OP_QUERY: begin
              budget_d = s_axis_tdata[ValueW +: BudgetW];
              lo_d     = '0;
              hi_d     = n_q;
              state_d  = S_QRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_LRD: begin
        if (idx_q == '0) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = {v_q, SumW'(v_q)};
          n_d           = n_q + CntW'(1);
          state_d       = S_IDLE;
        end else begin
          state_d = S_LCMP;
        end
      end
      S_LCMP: begin
        mem_req.we = 1'b1;
        if (alu_rsp.gt) begin
          mem_req.wdata = {rd_value, alu_rsp.sum};
          idx_d         = idx_m1;
          state_d       = S_LRD;
        end else begin
          mem_req.wdata = {v_q, alu_rsp.sum};
          n_d           = n_q + CntW'(1);
          state_d       = S_IDLE;
        end
      end
      S_QRD: begin
        mem_req.raddr = mid_calc[IdxW-1:0];
        if (lo_q >= hi_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_count_d = lo_q;
            out_ovf_d   = ovf_q;
            state_d     = S_IDLE;
          end
        end else begin
          mid_d   = mid_calc;
          state_d = S_QCMP;
        end
      end
      S_QCMP: begin
        mem_req.raddr = mid_q[IdxW-1:0];
        if (alu_rsp.gt) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + CntW'(1);
        end
        state_d = S_QRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    budget_q    <= budget_d;
    idx_q       <= idx_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= CntW'(Capacity))
    else $error("element count exceeds capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(ovf_q) |-> n_q == CntW'(Capacity))
    else $error("overflow flag set while the set was not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LCMP) |-> (idx_q != '0 && idx_q <= n_q))
    else $error("insertion slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QCMP) |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= n_q))
    else $error("search probe outside its bounds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result changed before it was taken");

endmodule

// ===== bench/tb_count_smallest_within_budget.sv =====
// Self-checking bench for count_smallest_within_budget: a short scripted opening, a fill past
// capacity, then randomized clear/load/query traffic with bursty input and stalling output.
// Depends on cswb_pkg and the count_smallest_within_budget RTL.
module tb_count_smallest_within_budget import cswb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            ovf;
  } answer_t;

  typedef struct packed {
    op_e                op;
    logic [ValueW-1:0]  value;
    logic [BudgetW-1:0] budget;
    logic               typed;
    answer_t            ans;
  } script_row_t;

  localparam int ScriptRows = 25;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [ValueW-1:0] held_values[$];
  logic              lost_load;
  answer_t           awaited_answers[$];
  int unsigned       mismatches;
  int unsigned       words_sent;
  int unsigned       burst_left;
  int unsigned       hold_req;
  bit                steady;

  script_row_t opening_script [ScriptRows] = '{
    '{OP_QUERY, 20'h00000, 32'h00000000, 1'b1, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'hFFFFF, 32'hFFFFFFFF, 1'b1, '{11'd0, 1'b0}},
    '{OP_NONE,  20'hFFFFF, 32'hFFFFFFFF, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h7FFFFFFF, 1'b1, '{11'd0, 1'b0}},
    '{OP_LOAD,  20'h00000, 32'hFFFFFFFF, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h00000000, 1'b1, '{11'd1, 1'b0}},
    '{OP_LOAD,  20'hFFFFF, 32'h00000000, 1'b0, '{11'd0, 1'b0}},
    '{OP_LOAD,  20'h00005, 32'h00000000, 1'b0, '{11'd0, 1'b0}},
    '{OP_LOAD,  20'h00005, 32'h00000000, 1'b0, '{11'd0, 1'b0}},
    '{OP_LOAD,  20'h00003, 32'h00000000, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h00000002, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h00000003, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h0000000C, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h0000000D, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h000FFFFF, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h0010000C, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'hFFFFFFFF, 1'b1, '{11'd5, 1'b0}},
    '{OP_NONE,  20'h00001, 32'h00000000, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'hFFFFFFFF, 1'b1, '{11'd5, 1'b0}},
    '{OP_CLEAR, 20'hFFFFF, 32'hFFFFFFFF, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'hFFFFFFFF, 1'b1, '{11'd0, 1'b0}},
    '{OP_LOAD,  20'h80000, 32'h00000000, 1'b0, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h0007FFFF, 1'b1, '{11'd0, 1'b0}},
    '{OP_QUERY, 20'h00000, 32'h00080000, 1'b1, '{11'd1, 1'b0}},
    '{OP_CLEAR, 20'h00000, 32'h00000000, 1'b0, '{11'd0, 1'b0}}
  };

  count_smallest_within_budget u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [CntW-1:0] fitting_count(input logic [BudgetW-1:0] budget);
    longint unsigned run_sum;
    int unsigned     n;
    run_sum = 0;
    n = 0;
    for (int i = 0; i < held_values.size(); i++) begin
      run_sum += held_values[i];
      if (run_sum > budget) break;
      n++;
    end
    return n[CntW-1:0];
  endfunction

  function automatic bit apply_word(input op_e op, input logic [ValueW-1:0] value,
                                    input logic [BudgetW-1:0] budget, output answer_t ans);
    int unsigned pos;
    ans = '0;
    case (op)
      OP_CLEAR: begin
        held_values.delete();
        lost_load = 1'b0;
      end
      OP_LOAD: begin
        if (held_values.size() >= Capacity) begin
          lost_load = 1'b1;
        end else begin
          pos = 0;
          while (pos < held_values.size() && held_values[pos] <= value) pos++;
          held_values.insert(pos, value);
        end
      end
      OP_QUERY: begin
        ans.count = fitting_count(budget);
        ans.ovf   = lost_load;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [BudgetW-1:0] pick_budget();
    longint unsigned run_sum;
    int unsigned     stop;
    run_sum = 0;
    stop = (held_values.size() == 0) ? 0 : $urandom_range(0, held_values.size() - 1);
    for (int k = 0; k <= stop && k < held_values.size(); k++) run_sum += held_values[k];
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3, 4:    return run_sum[BudgetW-1:0];
      5:       return run_sum[BudgetW-1:0] - 1'b1;
      default: return $urandom_range(0, 32'(run_sum));
    endcase
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ValueW'($urandom_range(1, 15));
      2:       return ValueW'(20'hFFFFF - $urandom_range(0, 3));
      3: begin
        if (held_values.size() != 0)
          return held_values[$urandom_range(0, held_values.size() - 1)];
        return ValueW'($urandom_range(0, 20'hFFFFF));
      end
      default: return ValueW'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  task automatic push_word(input op_e op, input logic [ValueW-1:0] value,
                           input logic [BudgetW-1:0] budget, input bit typed = 1'b0,
                           input answer_t typed_ans = '0);
    answer_t     ans;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InDataW - BudgetW - ValueW){1'b0}}, budget, value};
    do @(posedge clk_i); while (!s_axis_tready);
    if (apply_word(op, value, budget, ans))
      awaited_answers.insert(awaited_answers.size(), typed ? typed_ans : ans);
    if (op != OP_NONE) words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !steady) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned       cyc;
    int unsigned       hold_left;
    int unsigned       holds_done;
    cyc = 0;
    hold_left = 0;
    holds_done = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((cyc / 250) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (cyc % 5) != 0;
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        want = awaited_answers.pop_front();
        if (m_axis_tdata[CntW-1:0] !== want.count)
          report_mismatch($sformatf("count %0d, predicted %0d",
                                    m_axis_tdata[CntW-1:0], want.count));
        if (m_axis_tdata[CntW] !== want.ovf)
          report_mismatch($sformatf("overflowed %b, predicted %b",
                                    m_axis_tdata[CntW], want.ovf));
      end
    end
  end

  initial begin
    int unsigned       k;
    int unsigned       n;
    int unsigned       start;
    logic [ValueW-1:0] v;
    mismatches = 0;
    words_sent = 0;
    burst_left = 0;
    hold_req = 0;
    steady = 1'b0;
    lost_load = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_CLEAR;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < ScriptRows; r++)
      push_word(opening_script[r].op, opening_script[r].value, opening_script[r].budget,
                opening_script[r].typed, opening_script[r].ans);

    // Mostly ascending loads keep the fill cheap; a few scattered ones force long shifts.
    push_word(OP_CLEAR, '1, '1);
    for (k = 0; k < Capacity + 3; k++) begin
      if (k % 128 == 77) v = ValueW'($urandom_range(0, 20'hFFFFF));
      else if (k >= Capacity - 1) v = '1;
      else v = ValueW'(k * 1023 + $urandom_range(0, 1022));
      push_word(OP_LOAD, v, $urandom);
      if (k % 200 == 0) push_word(OP_QUERY, pick_value(), pick_budget());
    end
    repeat (6) push_word(OP_QUERY, pick_value(), pick_budget());
    push_word(OP_QUERY, '0, '1);
    push_word(OP_QUERY, '0, '0);
    push_word(OP_CLEAR, '0, '0);
    push_word(OP_QUERY, '0, '1);
    push_word(OP_LOAD, 20'd7, '0);

    hold_req++;
    steady = 1'b1;
    repeat (24) push_word(OP_QUERY, pick_value(), pick_budget());
    steady = 1'b0;

    start = words_sent;
    while (words_sent - start < 550) begin
      if (held_values.size() > 160) push_word(OP_CLEAR, pick_value(), $urandom);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) != 0) push_word(OP_CLEAR, pick_value(), $urandom);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 12);
        repeat (n) begin
          push_word(OP_LOAD, pick_value(), $urandom);
          if ($urandom_range(0, 7) == 0) push_word(OP_QUERY, pick_value(), pick_budget());
        end
        repeat ($urandom_range(1, 6)) push_word(OP_QUERY, pick_value(), pick_budget());
      end else begin
        push_word(op_e'($urandom_range(0, 3)), ValueW'($urandom_range(0, 20'hFFFFF)),
                  $urandom);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (2 * Capacity + 64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cswb_pkg.sv
src/cswb_mem.sv
src/cswb_alu.sv
src/count_smallest_within_budget.sv
bench/tb_count_smallest_within_budget.sv
